// File: src/fpfb_pkg.sv
package fpfb_pkg;

   // Width of the wide compares against the fixed decision constants
   localparam int WIDE_BITS = 54;

   localparam int NUMBER_BITS_DEFAULT = 54;

   localparam logic [WIDE_BITS-1:0] RANGE_LIMIT      = 54'd10000000000000000;
   localparam logic [WIDE_BITS-1:0] PSEUDO_EXCEPTION = 54'd46856248255981;

   localparam int BASE_COUNT    = 5;
   localparam int BASE_IDX_BITS = 3;
   localparam int BASE_BITS     = 15;
   localparam int BASE_CNT_BITS = 4;

   localparam logic [BASE_BITS-1:0] BASE_TWO   = 15'd2;
   localparam logic [BASE_BITS-1:0] BASE_THREE = 15'd3;
   localparam logic [BASE_BITS-1:0] BASE_SEVEN = 15'd7;
   localparam logic [BASE_BITS-1:0] BASE_SIXTY = 15'd61;
   localparam logic [BASE_BITS-1:0] BASE_LARGE = 15'd24251;

   localparam logic [BASE_IDX_BITS-1:0] LAST_BASE_IDX = 3'd4;

   function automatic logic [BASE_BITS-1:0] base_value(input logic [BASE_IDX_BITS-1:0] idx);
      logic [BASE_BITS-1:0] val;
      case (idx)
         3'd0: val = BASE_TWO;
         3'd1: val = BASE_THREE;
         3'd2: val = BASE_SEVEN;
         3'd3: val = BASE_SIXTY;
         3'd4: val = BASE_LARGE;
         default: val = BASE_TWO;
      endcase
      return val;
   endfunction

endpackage

// File: src/fermat_primality_fixed_bases.sv
// Fermat primality decision over the fixed bases 2, 3, 7, 61 and 24251.
//
// Input channel (req_): one word carries an unsigned number of NUMBER_BITS bits.
// Result channel (rsp_): one word per input, with is_prime and out_of_range.
// A word moves on a rising edge where valid is high and stall is low.
//
// Numbers below 2, above 10^16, the known pseudoprime 46856248255981 and the
// bases themselves are decided at once: the verdict is set as the input word is
// taken and passes through ST_FINISH into the output register. Every other
// number runs base^(n-1) mod n for each base in turn, by right-to-left
// square-and-multiply on one bit-serial modular multiplier that handles one
// multiplier bit per cycle. Per base that is a base reduction over the 15 base
// bits, then for each exponent bit one squaring and, where the bit is set, one
// product; the walk stops early at the first failing base.
//
// One number is in work at a time; req_stall is high from acceptance until the
// result is handed to the output register. A finished result waits in that
// register while rsp_stall is high and the next number is already taken.
// Reset empties the output register and returns the control to idle.
module fermat_primality_fixed_bases #(
   parameter int NUMBER_BITS = fpfb_pkg::NUMBER_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [NUMBER_BITS-1:0] req_number,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_is_prime,
   output logic                   rsp_out_of_range
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_EXP    = 3'd2;
   localparam logic [2:0] ST_MUL_R  = 3'd3;
   localparam logic [2:0] ST_MUL_P  = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0]                           state_ff, state_in;
   logic [NUMBER_BITS-1:0]               m_ff, m_in;
   logic [NUMBER_BITS-1:0]               e_ff, e_in;
   logic [NUMBER_BITS-1:0]               power_ff, power_in;
   logic [NUMBER_BITS-1:0]               result_ff, result_in;
   logic [fpfb_pkg::BASE_IDX_BITS-1:0]   base_idx_ff, base_idx_in;
   logic [fpfb_pkg::BASE_CNT_BITS-1:0]   bit_cnt_ff, bit_cnt_in;
   logic                                 verdict_ff, verdict_in;
   logic                                 oor_ff, oor_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_is_prime_ff, rsp_is_prime_in;
   logic                                 rsp_oor_ff, rsp_oor_in;

   logic [fpfb_pkg::WIDE_BITS-1:0]       number_wide;
   logic                                 is_base;
   logic [fpfb_pkg::BASE_BITS-1:0]       base_cur;
   logic [NUMBER_BITS:0]                 red_t;
   logic [NUMBER_BITS:0]                 red_s;
   logic                                 mul_start;
   logic                                 mul_done;
   logic [NUMBER_BITS-1:0]               mul_x;
   logic [NUMBER_BITS-1:0]               mul_prod;
   logic                                 out_free;
   logic                                 req_accept;

   assign number_wide = fpfb_pkg::WIDE_BITS'(req_number);
   assign is_base = (number_wide == fpfb_pkg::WIDE_BITS'(fpfb_pkg::BASE_TWO))   ||
                    (number_wide == fpfb_pkg::WIDE_BITS'(fpfb_pkg::BASE_THREE)) ||
                    (number_wide == fpfb_pkg::WIDE_BITS'(fpfb_pkg::BASE_SEVEN)) ||
                    (number_wide == fpfb_pkg::WIDE_BITS'(fpfb_pkg::BASE_SIXTY)) ||
                    (number_wide == fpfb_pkg::WIDE_BITS'(fpfb_pkg::BASE_LARGE));

   assign base_cur = fpfb_pkg::base_value(base_idx_ff);

   // base mod m, most significant base bit first; 2r + bit stays below 2m
   assign red_t = {power_ff, base_cur[bit_cnt_ff]};
   assign red_s = (red_t >= {1'b0, m_ff}) ? (red_t - {1'b0, m_ff}) : red_t;

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign mul_x = (state_ff == ST_EXP && e_ff[0]) ? result_ff : power_ff;

   always_comb begin
      state_in        = state_ff;
      m_in            = m_ff;
      e_in            = e_ff;
      power_in        = power_ff;
      result_in       = result_ff;
      base_idx_in     = base_idx_ff;
      bit_cnt_in      = bit_cnt_ff;
      verdict_in      = verdict_ff;
      oor_in          = oor_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_is_prime_in = rsp_is_prime_ff;
      rsp_oor_in      = rsp_oor_ff;
      mul_start       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               m_in        = req_number;
               base_idx_in = '0;
               power_in    = '0;
               bit_cnt_in  = fpfb_pkg::BASE_CNT_BITS'(fpfb_pkg::BASE_BITS - 1);
               verdict_in  = 1'b0;
               oor_in      = 1'b0;
               state_in    = ST_FINISH;
               if (number_wide > fpfb_pkg::RANGE_LIMIT) begin
                  oor_in = 1'b1;
               end else if (number_wide < fpfb_pkg::WIDE_BITS'(2) ||
                            number_wide == fpfb_pkg::PSEUDO_EXCEPTION) begin
                  verdict_in = 1'b0;
               end else if (is_base) begin
                  verdict_in = 1'b1;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            power_in = red_s[NUMBER_BITS-1:0];
            if (bit_cnt_ff == '0) begin
               result_in = NUMBER_BITS'(1);
               e_in      = m_ff - NUMBER_BITS'(1);
               state_in  = ST_EXP;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         ST_EXP: begin
            if (e_ff == '0) begin
               if (result_ff != NUMBER_BITS'(1)) begin
                  verdict_in = 1'b0;
                  state_in   = ST_FINISH;
               end else if (base_idx_ff == fpfb_pkg::LAST_BASE_IDX) begin
                  verdict_in = 1'b1;
                  state_in   = ST_FINISH;
               end else begin
                  base_idx_in = base_idx_ff + 1'b1;
                  power_in    = '0;
                  bit_cnt_in  = fpfb_pkg::BASE_CNT_BITS'(fpfb_pkg::BASE_BITS - 1);
                  state_in    = ST_REDUCE;
               end
            end else begin
               mul_start = 1'b1;
               state_in  = e_ff[0] ? ST_MUL_R : ST_MUL_P;
            end
         end
         ST_MUL_R: begin
            if (mul_done) begin
               result_in = mul_prod;
               mul_start = 1'b1;
               state_in  = ST_MUL_P;
            end
         end
         ST_MUL_P: begin
            if (mul_done) begin
               power_in = mul_prod;
               e_in     = {1'b0, e_ff[NUMBER_BITS-1:1]};
               state_in = ST_EXP;
            end
         end
         ST_FINISH: begin
            // hold the verdict until the output register can take it
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_is_prime_in = verdict_ff;
               rsp_oor_in      = oor_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   fpfb_mulmod #(
      .NUMBER_BITS(NUMBER_BITS)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_x    (mul_x),
      .op_y    (power_ff),
      .modulus (m_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   always_ff @(posedge clock) begin
      m_ff            <= m_in;
      e_ff            <= e_in;
      power_ff        <= power_in;
      result_ff       <= result_in;
      bit_cnt_ff      <= bit_cnt_in;
      verdict_ff      <= verdict_in;
      oor_ff          <= oor_in;
      rsp_is_prime_ff <= rsp_is_prime_in;
      rsp_oor_ff      <= rsp_oor_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_idx_ff  <= base_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_prime     = rsp_is_prime_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   a_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_MUL_R || state_ff == ST_MUL_P))
      else $error("multiplier finished outside a multiply state");

   a_power_reduced: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXP |-> power_ff < m_ff)
      else $error("power not reduced below the modulus");

   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXP |-> result_ff < m_ff)
      else $error("running result not reduced below the modulus");

   a_word_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result word raised without a finished verdict");

   a_base_idx_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> base_idx_ff <= fpfb_pkg::LAST_BASE_IDX)
      else $error("base index beyond the last base");

endmodule

// File: src/fpfb_mulmod.sv
module fpfb_mulmod #(
   parameter int NUMBER_BITS = fpfb_pkg::NUMBER_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [NUMBER_BITS-1:0] op_x,
   input  logic [NUMBER_BITS-1:0] op_y,
   input  logic [NUMBER_BITS-1:0] modulus,
   output logic                   done,
   output logic [NUMBER_BITS-1:0] product
);

   logic [NUMBER_BITS-1:0] acc_ff, acc_in;
   logic [NUMBER_BITS-1:0] x_ff, x_in;
   logic [NUMBER_BITS-1:0] y_ff, y_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   // a, b < m: one add and at most one subtract
   function automatic logic [NUMBER_BITS-1:0] add_mod(input logic [NUMBER_BITS-1:0] a,
                                                      input logic [NUMBER_BITS-1:0] b,
                                                      input logic [NUMBER_BITS-1:0] m);
      logic [NUMBER_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[NUMBER_BITS-1:0];
   endfunction

   // one multiplier bit per cycle, least significant first; stop once it runs dry
   always_comb begin
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         x_in    = op_x;
         y_in    = op_y;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (y_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (y_ff[0]) begin
               acc_in = add_mod(acc_ff, x_ff, modulus);
            end
            x_in = add_mod(x_ff, x_ff, modulus);
            y_in = {1'b0, y_ff[NUMBER_BITS-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule
